// ----- hdl/sl4s_pkg.sv -----
// shared types, character codes and helpers for the sized literal parser
// no dependencies; imported by sized_literal_to_four_state, sl4s_literal_checker and the testbench
package sl4s_pkg;

  localparam int MAX_BITS = 64;
  localparam int WIDTH_W  = 7;

  typedef enum logic [2:0] {
    PH_SIZE  = 3'b001,
    PH_BASE  = 3'b010,
    PH_DIGIT = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_DEC = 2'd2,
    RADIX_HEX = 2'd3
  } radix_t;

  typedef enum logic [1:0] {
    PAD_LOW = 2'd0,
    PAD_X   = 2'd1,
    PAD_Z   = 2'd2
  } pad_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_QUEST = 8'h3f;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_Z     = 8'h7a;

  localparam logic [WIDTH_W-1:0] MAX_W   = WIDTH_W'(MAX_BITS);
  localparam logic [WIDTH_W-1:0] SIZE_SAT = 7'd127;

  // ones in the low n bits, all ones from 64 up
  function automatic logic [63:0] low_mask(input logic [WIDTH_W-1:0] n);
    logic [63:0] r;
    if (n >= 7'd64) r = '1;
    else r = (64'd1 << n[5:0]) - 64'd1;
    return r;
  endfunction

endpackage

// ----- hdl/sized_literal_to_four_state.sv -----
// sized number literal parser: characters in, width plus value/unknown planes out
// depends on sl4s_pkg
//
//  channel | signals                         | role
//  in      | in_valid in_ready char_code     | one character per word, last_char
//          | last_char                       | closes the literal
//  out     | out_valid out_ready width       | one word per literal, after the
//          | value_plane unknown_plane       | character that carries last_char
//
// one character per cycle while in_ready is high; the parse state updates in the accepting cycle
// the result lands in the output register in the cycle after the last character is accepted
// in_ready drops only while a result is held and out_ready is low
// rst (synchronous) returns the parse state to the size field and empties the output
module sized_literal_to_four_state (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    char_code,
  input  logic                          last_char,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sl4s_pkg::WIDTH_W-1:0]  width,
  output logic [63:0]                   value_plane,
  output logic [63:0]                   unknown_plane
);
  import sl4s_pkg::*;

  phase_t               phase, phase_next;
  logic [WIDTH_W-1:0]   size_accum, size_accum_next;
  radix_t               radix_kind, radix_kind_next;
  logic [63:0]          value_shift, value_shift_next;
  logic [63:0]          unknown_shift, unknown_shift_next;
  logic [WIDTH_W-1:0]   digit_bits_seen, digit_bits_seen_next;
  pad_t                 pad_kind, pad_kind_next;
  logic                 first_digit_seen, first_digit_seen_next;

  logic                 in_fire;
  logic [7:0]           c;
  logic                 is_num;
  logic [3:0]           num_val;
  logic [10:0]          size_sum;
  logic                 base_ok;
  radix_t               base_radix;
  logic [3:0]           dig_val, dig_unk, dig_mask;
  logic                 dig_ok;
  pad_t                 dig_pad;
  logic [31:0]          dec_sum;
  logic [WIDTH_W-1:0]   bits_sum;

  logic [WIDTH_W-1:0]   res_w;
  logic [63:0]          wm, dm, res_v, res_u;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    c = char_code;
    if (char_code >= CH_UA && char_code <= CH_UZ) c = char_code + 8'd32;
  end

  assign is_num   = (c >= CH_0) && (c <= CH_9);
  assign num_val  = 4'(c - CH_0);
  assign size_sum = 11'(size_accum) * 11'd10 + 11'(num_val);
  // multiply by ten as two shifts, wraps at 32 bits
  assign dec_sum  = (value_shift[31:0] << 3) + (value_shift[31:0] << 1) + 32'(num_val);

  always_comb begin
    base_ok    = 1'b1;
    base_radix = RADIX_BIN;
    if (c == CH_B)      base_radix = RADIX_BIN;
    else if (c == CH_O) base_radix = RADIX_OCT;
    else if (c == CH_D) base_radix = RADIX_DEC;
    else if (c == CH_H) base_radix = RADIX_HEX;
    else                base_ok = 1'b0;
  end

  // digit decode for the shifting radixes
  always_comb begin
    dig_val = 4'd0;
    dig_unk = 4'd0;
    dig_pad = PAD_LOW;
    dig_ok  = 1'b1;
    unique case (radix_kind)
      RADIX_BIN: dig_mask = 4'b0001;
      RADIX_OCT: dig_mask = 4'b0111;
      default:   dig_mask = 4'b1111;
    endcase
    if (c == CH_X) begin
      dig_val = 4'hf;
      dig_unk = 4'hf;
      dig_pad = PAD_X;
    end else if (c == CH_Z || c == CH_QUEST) begin
      dig_unk = 4'hf;
      dig_pad = PAD_Z;
    end else if (is_num) begin
      dig_val = num_val;
    end else if (c >= CH_A && c <= CH_F) begin
      dig_val = 4'(c - CH_A) + 4'd10;
    end else begin
      dig_ok = 1'b0;
    end
    // known digit too large for the radix is dropped
    if (dig_unk == 4'd0 && (dig_val & ~dig_mask) != 4'd0) dig_ok = 1'b0;
  end

  always_comb begin
    phase_next            = phase;
    size_accum_next       = size_accum;
    radix_kind_next       = radix_kind;
    value_shift_next      = value_shift;
    unknown_shift_next    = unknown_shift;
    digit_bits_seen_next  = digit_bits_seen;
    pad_kind_next         = pad_kind;
    first_digit_seen_next = first_digit_seen;
    bits_sum              = digit_bits_seen;
    if (c != CH_SPACE && c != CH_UNDER) begin
      unique case (phase)
        PH_SIZE: begin
          if (is_num) begin
            size_accum_next = (size_sum > 11'(SIZE_SAT)) ? SIZE_SAT : size_sum[WIDTH_W-1:0];
          end else if (c == CH_APOS) begin
            phase_next = PH_BASE;
          end else if (base_ok) begin
            radix_kind_next = base_radix;
            phase_next      = PH_DIGIT;
          end
        end
        PH_BASE: begin
          if (base_ok) begin
            radix_kind_next = base_radix;
            phase_next      = PH_DIGIT;
          end
        end
        PH_DIGIT: begin
          if (radix_kind == RADIX_DEC) begin
            if (is_num) value_shift_next = {32'd0, dec_sum};
          end else if (dig_ok) begin
            if (!first_digit_seen) begin
              first_digit_seen_next = 1'b1;
              pad_kind_next         = dig_pad;
            end
            case (radix_kind)
              RADIX_BIN: begin
                value_shift_next   = {value_shift[62:0], dig_val[0]};
                unknown_shift_next = {unknown_shift[62:0], dig_unk[0]};
                bits_sum           = digit_bits_seen + 7'd1;
              end
              RADIX_OCT: begin
                value_shift_next   = {value_shift[60:0], dig_val[2:0]};
                unknown_shift_next = {unknown_shift[60:0], dig_unk[2:0]};
                bits_sum           = digit_bits_seen + 7'd3;
              end
              default: begin
                value_shift_next   = {value_shift[59:0], dig_val};
                unknown_shift_next = {unknown_shift[59:0], dig_unk};
                bits_sum           = digit_bits_seen + 7'd4;
              end
            endcase
            digit_bits_seen_next = (bits_sum > 7'd64) ? 7'd64 : bits_sum;
          end
        end
        default: phase_next = PH_SIZE;
      endcase
    end
  end

  // final width, masks and padding from the updated state
  always_comb begin
    res_w = (size_accum_next == '0 || size_accum_next > MAX_W) ? MAX_W : size_accum_next;
    wm    = low_mask(res_w);
    dm    = low_mask(digit_bits_seen_next);
    if (radix_kind_next == RADIX_DEC) begin
      res_v = value_shift_next;
      res_u = 64'd0;
    end else begin
      res_v = value_shift_next & dm;
      res_u = unknown_shift_next & dm;
      case (pad_kind_next)
        PAD_X: begin
          res_v = res_v | ~dm;
          res_u = res_u | ~dm;
        end
        PAD_Z:   res_u = res_u | ~dm;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_fire && last_char)) begin
      phase            <= PH_SIZE;
      size_accum       <= '0;
      radix_kind       <= RADIX_BIN;
      value_shift      <= '0;
      unknown_shift    <= '0;
      digit_bits_seen  <= '0;
      pad_kind         <= PAD_LOW;
      first_digit_seen <= 1'b0;
    end else if (in_fire) begin
      phase            <= phase_next;
      size_accum       <= size_accum_next;
      radix_kind       <= radix_kind_next;
      value_shift      <= value_shift_next;
      unknown_shift    <= unknown_shift_next;
      digit_bits_seen  <= digit_bits_seen_next;
      pad_kind         <= pad_kind_next;
      first_digit_seen <= first_digit_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && last_char) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && last_char) begin
      width         <= res_w;
      value_plane   <= res_v & wm;
      unknown_plane <= res_u & wm;
    end
  end

  a_width_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (width != '0 && width <= MAX_W))
    else $error("result width out of range");

  a_above_width_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (((value_plane | unknown_plane) & ~low_mask(width)) == 64'd0))
    else $error("planes set above width");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_fire && last_char) |=> out_valid)
    else $error("last character gave no result");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    (in_fire && last_char) |=> (phase == PH_SIZE && digit_bits_seen == '0
                                && size_accum == '0 && !first_digit_seen))
    else $error("parse state not cleared after literal");

  a_bits_saturate: assert property (@(posedge clk) disable iff (rst)
    digit_bits_seen <= 7'd64)
    else $error("digit bit count past 64");

endmodule

// ----- dv/sl4s_literal_checker.sv -----
// checker for the sized literal parser: predicts each literal word from the characters
// it sees accepted and compares every output word; depends on sl4s_pkg
module sl4s_literal_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [7:0]                   char_code,
  input  logic                         last_char,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [sl4s_pkg::WIDTH_W-1:0] width,
  input  logic [63:0]                  value_plane,
  input  logic [63:0]                  unknown_plane,
  output int                           fail_count,
  output int                           pending,
  output int                           checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import sl4s_pkg::*;

  typedef struct packed {
    logic [WIDTH_W-1:0] width;
    logic [63:0]        value;
    logic [63:0]        unknown;
  } literal_word_t;

  literal_word_t expected_literals[$];

  // parse state of the predictor
  phase_t             ph;
  logic [WIDTH_W-1:0] size_acc;
  radix_t             rdx;
  logic [63:0]        vs;
  logic [63:0]        us;
  logic [WIDTH_W-1:0] nbits;
  pad_t               pad;
  logic               seen_first;

  int fails = 0;
  int n_checked = 0;

  function automatic logic [63:0] fill_low(input logic [WIDTH_W-1:0] n);
    return (n >= 7'd64) ? '1 : ~(64'hFFFF_FFFF_FFFF_FFFF << n);
  endfunction

  task automatic clear_parse();
    ph         = PH_SIZE;
    size_acc   = '0;
    rdx        = RADIX_BIN;
    vs         = '0;
    us         = '0;
    nbits      = '0;
    pad        = PAD_LOW;
    seen_first = 1'b0;
  endtask

  task automatic take_base(input logic [7:0] c);
    case (c)
      CH_B: begin rdx = RADIX_BIN; ph = PH_DIGIT; end
      CH_O: begin rdx = RADIX_OCT; ph = PH_DIGIT; end
      CH_D: begin rdx = RADIX_DEC; ph = PH_DIGIT; end
      CH_H: begin rdx = RADIX_HEX; ph = PH_DIGIT; end
      default: ;
    endcase
  endtask

  task automatic parse_char(input logic [7:0] raw, input logic fin);
    logic [7:0]         c;
    int                 s;
    int                 k;
    int                 val;
    int                 unk;
    int                 m;
    int                 nb;
    bit                 skip;
    pad_t               digit_pad;
    logic [WIDTH_W-1:0] w;
    logic [63:0]        dm;
    logic [63:0]        v;
    logic [63:0]        u;
    literal_word_t      r;
    c = (raw >= CH_UA && raw <= CH_UZ) ? raw + 8'd32 : raw;
    if (c != CH_SPACE && c != CH_UNDER) begin
      case (ph)
        PH_SIZE: begin
          if (c >= CH_0 && c <= CH_9) begin
            s = int'(size_acc) * 10 + int'(c - CH_0);
            size_acc = (s > 127) ? SIZE_SAT : WIDTH_W'(s);
          end else if (c == CH_APOS) begin
            ph = PH_BASE;
          end else begin
            take_base(c);
          end
        end
        PH_BASE: take_base(c);
        default: begin
          if (rdx == RADIX_DEC) begin
            if (c >= CH_0 && c <= CH_9)
              vs = (vs * 64'd10 + 64'(c - CH_0)) & 64'hFFFF_FFFF;
          end else begin
            k = (rdx == RADIX_BIN) ? 1 : ((rdx == RADIX_OCT) ? 3 : 4);
            m = (1 << k) - 1;
            skip = 1'b0;
            val = 0;
            unk = 0;
            digit_pad = PAD_LOW;
            if (c == CH_X) begin
              val = 15; unk = 15; digit_pad = PAD_X;
            end else if (c == CH_Z || c == CH_QUEST) begin
              unk = 15; digit_pad = PAD_Z;
            end else if (c >= CH_0 && c <= CH_9) begin
              val = int'(c - CH_0);
            end else if (c >= CH_A && c <= CH_F) begin
              val = int'(c - CH_A) + 10;
            end else begin
              skip = 1'b1;
            end
            // a known digit too big for the radix is dropped
            if (val > m && unk == 0) skip = 1'b1;
            if (!skip) begin
              if (!seen_first) begin
                seen_first = 1'b1;
                pad = digit_pad;
              end
              vs = (vs << k) | 64'(val & m);
              us = (us << k) | 64'(unk & m);
              nb = int'(nbits) + k;
              nbits = (nb > 64) ? 7'd64 : WIDTH_W'(nb);
            end
          end
        end
      endcase
    end
    if (fin) begin
      w = size_acc;
      if (w == 0 || w > MAX_W) w = MAX_W;
      if (rdx == RADIX_DEC) begin
        v = vs;
        u = '0;
      end else begin
        dm = fill_low(nbits);
        v = vs & dm;
        u = us & dm;
        if (pad == PAD_X) begin
          v |= ~dm;
          u |= ~dm;
        end else if (pad == PAD_Z) begin
          u |= ~dm;
        end
      end
      r.width   = w;
      r.value   = v & fill_low(w);
      r.unknown = u & fill_low(w);
      expected_literals.push_back(r);
      clear_parse();
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    literal_word_t e;
    if (rst) begin
      clear_parse();
      expected_literals.delete();
    end else begin
      // check before predicting: a word never leaves in the cycle its last character enters
      if (out_valid && out_ready) begin
        if (expected_literals.size() == 0) begin
          fails++;
          $display("%0t ns: output word with none expected, actual width %0d value %h unknown %h",
                   $time, width, value_plane, unknown_plane);
        end else begin
          e = expected_literals.pop_front();
          compare_field("width", 64'(e.width), 64'(width));
          compare_field("value_plane", e.value, value_plane);
          compare_field("unknown_plane", e.unknown, unknown_plane);
          n_checked++;
        end
      end
      if (in_valid && in_ready) parse_char(char_code, last_char);
    end
    fail_count <= fails;
    pending    <= expected_literals.size();
    checked    <= n_checked;
  end

endmodule

// ----- dv/sized_literal_to_four_state_tb.sv -----
// top of the sized literal parser testbench: clock, reset, character stimulus,
// output back-pressure and verdict; depends on sl4s_pkg and sl4s_literal_checker
module sized_literal_to_four_state_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sl4s_pkg::*;

  localparam int CHAR_TARGET = 1000;
  localparam int CYCLE_LIMIT = 400000;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         char_code;
  logic               last_char;
  logic               out_valid;
  logic               out_ready;
  logic [WIDTH_W-1:0] width;
  logic [63:0]        value_plane;
  logic [63:0]        unknown_plane;

  int fail_count;
  int pending;
  int checked;
  int cycle_count = 0;
  int chars_sent = 0;
  int lits_sent = 0;
  bit burst = 1'b0;
  bit started = 1'b0;

  byte unsigned lit_chars[$];

  sized_literal_to_four_state uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .char_code     (char_code),
    .last_char     (last_char),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .width         (width),
    .value_plane   (value_plane),
    .unknown_plane (unknown_plane)
  );

  sl4s_literal_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .char_code     (char_code),
    .last_char     (last_char),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .width         (width),
    .value_plane   (value_plane),
    .unknown_plane (unknown_plane),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) lit_chars.push_back(s[i]);
  endfunction

  // literal: optional size, apostrophe, base letter, digits, junk; or raw bytes
  task automatic compose_literal();
    int          bi;
    int          nd;
    int          r;
    byte unsigned b;
    string       bases;
    string       hexes;
    string       xs;
    string       zs;
    bases = "bodh";
    hexes = "0123456789abcdefABCDEF";
    xs = "xX";
    zs = "zZ?";
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) lit_chars.push_back(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 5))
        0: ;
        1: add_text("0");
        2: add_text($sformatf("%0d", $urandom_range(1, 64)));
        3: add_text($urandom_range(0, 1) ? "64" : "65");
        4: add_text($sformatf("%0d", $urandom_range(66, 999)));
        default: add_text($sformatf("%0d", $urandom_range(1, 16)));
      endcase
      if ($urandom_range(0, 7) != 0) add_text("'");
      bi = $urandom_range(0, 3);
      if ($urandom_range(0, 15) != 0) begin
        b = bases[bi];
        if ($urandom_range(0, 1)) b = b - 8'd32;
        lit_chars.push_back(b);
      end
      nd = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 70) : $urandom_range(0, 12);
      repeat (nd) begin
        r = $urandom_range(0, 99);
        if (r < 8) b = xs[$urandom_range(0, 1)];
        else if (r < 16) b = zs[$urandom_range(0, 2)];
        else if (r < 22) b = $urandom_range(0, 1) ? CH_UNDER : CH_SPACE;
        else if (r < 26) b = 8'($urandom_range(0, 255));
        else begin
          case (bi)
            0: b = CH_0 + 8'($urandom_range(0, 1));
            1: b = CH_0 + 8'($urandom_range(0, 7));
            2: b = CH_0 + 8'($urandom_range(0, 9));
            default: b = hexes[$urandom_range(0, 21)];
          endcase
        end
        lit_chars.push_back(b);
      end
    end
    if (lit_chars.size() == 0) lit_chars.push_back(8'($urandom_range(0, 255)));
  endtask

  // sends the queued literal, last_char on its final word
  task automatic send_lit();
    int gap;
    for (int i = 0; i < lit_chars.size(); i++) begin
      gap = burst ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid  <= 1'b1;
      char_code <= lit_chars[i];
      last_char <= (i == lit_chars.size() - 1);
      do @(posedge clk); while (!in_ready);
      chars_sent++;
    end
    lit_chars.delete();
    lits_sent++;
  endtask

  // output side stalls before each word, except in burst mode
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (started);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    char_code = 8'h00;
    last_char = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    started = 1'b1;

    // x pad with a nul character mixed in
    add_text("8'bx");
    lit_chars.push_back(8'h00);
    add_text("1");
    send_lit();
    // zero size, upper case base, z pad
    add_text("0'Oz7");
    send_lit();
    // oversized size, base without apostrophe, skipped characters, decimal
    burst = 1'b1;
    add_text("99d_4 9");
    send_lit();
    // size only, no base letter
    add_text("5");
    send_lit();
    // no size, question mark pad, a letter that is no hex digit
    burst = 1'b0;
    add_text("'h?g");
    send_lit();
    lit_chars.push_back(8'hFF);
    send_lit();

    while (chars_sent < CHAR_TARGET) begin
      burst = ($urandom_range(0, 3) == 0);
      compose_literal();
      send_lit();
    end
    in_valid <= 1'b0;
    burst = 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d literals in %0d characters, compared %0d output words", lits_sent,
             chars_sent, checked);
    $display("covered sizes from none to saturated, all radixes, x/z padding and junk bytes");
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/sl4s_pkg.sv
hdl/sized_literal_to_four_state.sv
dv/sl4s_literal_checker.sv
dv/sized_literal_to_four_state_tb.sv
